FILE: hw/rtl/rs_syndrome_calculator_defines.svh
// Assertion macros used by the syndrome calculator checker
`ifndef RS_SYNDROME_CALCULATOR_DEFINES_SVH
`define RS_SYNDROME_CALCULATOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define RSSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define RSSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rs_syn_pkg.sv
package rs_syn_pkg;

    localparam int unsigned MAX_SYNDROMES = 32;
    localparam int unsigned IDX_W = (MAX_SYNDROMES > 1) ? $clog2(MAX_SYNDROMES) : 1;
    localparam int unsigned CNT_W = 6;
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(10);
    localparam logic [8:0] GF_POLY = 9'h11d;

    // One finished codeword: all accumulators plus the index of the final syndrome
    typedef struct packed {
        logic [MAX_SYNDROMES-1:0][7:0] acc;
        logic [IDX_W-1:0]              last_idx;
    } t_snap;

    // Queue occupancy seen by the front and back parts
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    // Multiply by alpha with reduction by the field polynomial
    function automatic logic [7:0] gf_times_two(input logic [7:0] a);
        logic [8:0] v;
        v = {a, 1'b0};
        if (v[8]) begin
            v = v ^ GF_POLY;
        end
        return v[7:0];
    endfunction

    // Shift-and-add field multiply; a constant b folds it to an XOR network
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                r = r ^ x;
            end
            x = gf_times_two(x);
        end
        return r;
    endfunction

    // alpha to the power e, evaluated at elaboration
    function automatic logic [7:0] gf_pow2(input int unsigned e);
        logic [7:0] p;
        p = 8'h01;
        for (int unsigned k = 0; k < MAX_SYNDROMES; k++) begin
            if (k < e) begin
                p = gf_times_two(p);
            end
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/rs_syn_front.sv
module rs_syn_front
    import rs_syn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,
    input  logic             i_s_axis_tlast,
    input  t_q_stat          i_q_stat,
    output logic             o_push,
    output t_snap            o_snap
);

    logic [MAX_SYNDROMES-1:0][7:0] r_acc;
    logic [MAX_SYNDROMES-1:0][7:0] n_acc;
    logic [CNT_W-1:0]              r_count;
    logic                          s_accept;
    logic [CNT_W:0]                s_n;

    // Take bytes whenever a queue slot is free for a finished word
    assign o_s_axis_tready = !i_q_stat.full;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Horner step per lane: constant multiply by alpha^i, then add the byte
    for (genvar g = 0; g < MAX_SYNDROMES; g++) begin : g_lane
        localparam logic [7:0] POW = gf_pow2(g);
        assign n_acc[g] = gf_mul(r_acc[g], POW) ^ i_s_axis_tdata;
    end

    // Clamp the emitted count to 1..MAX_SYNDROMES
    always_comb begin
        priority if (r_count == '0) begin
            s_n = (CNT_W+1)'(1);
        end else if ({1'b0, r_count} > (CNT_W+1)'(MAX_SYNDROMES)) begin
            s_n = (CNT_W+1)'(MAX_SYNDROMES);
        end else begin
            s_n = {1'b0, r_count};
        end
    end

    assign o_push          = s_accept && i_s_axis_tlast;
    assign o_snap.acc      = n_acc;
    assign o_snap.last_idx = IDX_W'(s_n - (CNT_W+1)'(1));

    // Count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // Accumulators: update on each beat, clear after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (s_accept) begin
            if (i_s_axis_tlast) begin
                r_acc <= '0;
            end else begin
                r_acc <= n_acc;
            end
        end
    end

endmodule

FILE: hw/rtl/rs_syn_queue.sv
module rs_syn_queue
    import rs_syn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_snap   i_snap,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_snap   o_head
);

    t_snap      r_slot0;
    t_snap      r_slot1;
    logic       r_vld0;
    logic       r_vld1;
    logic       n_vld0;
    logic       n_vld1;
    logic       s_mid0;
    logic       s_mid1;

    assign o_stat.full  = r_vld0 && r_vld1;
    assign o_stat.valid = r_vld0;
    assign o_head       = r_slot0;

    // Valid bits: apply the pop first, then place the push in the first free slot
    always_comb begin
        s_mid0 = i_pop ? r_vld1 : r_vld0;
        s_mid1 = i_pop ? 1'b0   : r_vld1;
        n_vld0 = s_mid0;
        n_vld1 = s_mid1;
        if (i_push) begin
            if (!s_mid0) begin
                n_vld0 = 1'b1;
            end else begin
                n_vld1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            r_vld0 <= n_vld0;
            r_vld1 <= n_vld1;
        end
    end

    // Payload: write the new word where it lands, else advance slot 1 on pop
    always_ff @(posedge i_clk) begin
        if (i_push && !s_mid0) begin
            r_slot0 <= i_snap;
        end else if (i_pop) begin
            r_slot0 <= r_slot1;
        end
        if (i_push && s_mid0) begin
            r_slot1 <= i_snap;
        end
    end

endmodule

FILE: hw/rtl/rs_syn_back.sv
module rs_syn_back
    import rs_syn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_snap       i_head,
    output logic        o_pop,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic [MAX_SYNDROMES-1:0][7:0] r_shift;
    logic [IDX_W-1:0]              r_idx;
    logic [IDX_W-1:0]              r_last_idx;
    logic                          r_busy;
    logic                          r_out_vld;
    logic [7:0]                    r_out_val;
    logic [4:0]                    r_out_idx;
    logic                          r_out_last;
    logic                          s_emit;
    logic                          s_is_last;

    assign s_emit    = r_busy && (!r_out_vld || i_m_axis_tready);
    assign s_is_last = (r_idx == r_last_idx);
    assign o_pop     = i_q_stat.valid && (!r_busy || (s_emit && s_is_last));

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {3'b000, r_out_idx, r_out_val};
    assign o_m_axis_tlast  = r_out_last;

    // Control: run state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (s_emit && s_is_last) begin
                r_busy <= 1'b0;
            end
            if (s_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath: load a word, then shift one syndrome out per beat
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift    <= i_head.acc;
            r_idx      <= '0;
            r_last_idx <= i_head.last_idx;
        end else if (s_emit) begin
            r_shift <= {8'h00, r_shift[MAX_SYNDROMES-1:1]};
            r_idx   <= r_idx + IDX_W'(1);
        end
        if (s_emit) begin
            r_out_val  <= r_shift[0];
            r_out_idx  <= 5'(r_idx);
            r_out_last <= s_is_last;
        end
    end

endmodule

FILE: hw/rtl/rs_syndrome_calculator.sv
// Output: a word's syndromes pass the word queue, shift register and output register once its
// final byte is taken; then one syndrome per cycle in index order while the sink keeps up.
// Throughput: one byte per cycle; the two-slot word queue fills and drops ready only when
// two finished words wait behind the one being emitted.
// Reset (synchronous, active low): accumulators cleared, count set to 10, queue and output
// emptied.
module rs_syndrome_calculator
    import rs_syn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,      // syndrome_count
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] code_byte
    input  logic        i_s_axis_tlast,   // end_of_word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] syndrome_value, [12:8] syndrome_index
    output logic        o_m_axis_tlast    // last_syndrome
);

    t_q_stat s_q_stat;
    t_snap   s_snap;
    t_snap   s_head;
    logic    s_push;
    logic    s_pop;

    rs_syn_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_stat        (s_q_stat),
        .o_push          (s_push),
        .o_snap          (s_snap)
    );

    rs_syn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_snap  (s_snap),
        .i_pop   (s_pop),
        .o_stat  (s_q_stat),
        .o_head  (s_head)
    );

    rs_syn_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (s_q_stat),
        .i_head          (s_head),
        .o_pop           (s_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: hw/rtl/rs_syn_checker.sv
`include "rs_syndrome_calculator_defines.svh"

module rs_syn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    logic [3:0] r_pend;
    logic [4:0] r_exp_idx;
    logic       s_in_end;
    logic       s_out_end;
    logic       s_out_beat;

    assign s_in_end   = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;
    assign s_out_beat = o_m_axis_tvalid && i_m_axis_tready;
    assign s_out_end  = s_out_beat && o_m_axis_tlast;

    // Track words ended at the input but not yet fully delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 4'(s_in_end) - 4'(s_out_end);
        end
    end

    // Expected index of the next delivered syndrome
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (s_out_beat) begin
            r_exp_idx <= o_m_axis_tlast ? 5'd0 : r_exp_idx + 5'd1;
        end
    end

    `RSSC_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast),
        "stalled syndrome beat changed")
    `RSSC_ASSERT_NOW(a_idx_order, s_out_beat, o_m_axis_tdata[12:8] == r_exp_idx,
        "syndrome index out of sequence")
    `RSSC_ASSERT_NOW(a_no_spurious, o_m_axis_tvalid, r_pend != 4'd0,
        "syndrome shown with no finished word pending")
    `RSSC_ASSERT_NOW(a_ready_low, !o_s_axis_tready, r_pend >= 4'd2,
        "input stalled with fewer than two words pending")

endmodule

bind rs_syndrome_calculator rs_syn_checker u_rs_syn_checker (.*);
